// ===== rtl/tapc_pkg.sv =====
// types and constants shared by the touch tap classifier and its checker
`timescale 1ns / 1ps

package tapc_pkg;

    localparam int TAP_X_W   = 11;
    localparam int TAP_Y_W   = 10;
    localparam int ROW_W     = 7;
    localparam int OUT_W     = 32;
    localparam int SLOP_W    = 11;
    localparam int WIDTH_W   = 11;
    localparam int MARGIN_W  = 10;
    localparam int HEIGHT_W  = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [SLOP_W-1:0]   TAP_SLOP_RESET      = SLOP_W'(40);
    localparam logic [WIDTH_W-1:0]  SIDEBAR_WIDTH_RESET = WIDTH_W'(410);
    localparam logic [MARGIN_W-1:0] TOP_MARGIN_RESET    = '0;
    localparam logic [HEIGHT_W-1:0] MIN_ROW_HEIGHT      = HEIGHT_W'(8);
    localparam logic [ROW_W-1:0]    ROW_MAX             = ROW_W'(127);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE     = 3'd0,
        CFG_TAP_SLOP   = 3'd1,
        CFG_SB_WIDTH   = 3'd2,
        CFG_SB_MARGIN  = 3'd3,
        CFG_SB_HEIGHT  = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SLOP,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } tapc_state_t;

endpackage

// ===== rtl/touch_tap_classifier.sv =====
// touch tap classifier: press/release tracking, slop check and sidebar row lookup
`timescale 1ns / 1ps

// One touch poll is taken per input word. Polls that keep or start a touch, polls
// with no touch after a release, and all polls while disabled are handled in the
// idle state. A release poll runs a sequencer over one shared multiplier (dx
// squared, dy squared, slop squared, one step each); a release that traveled
// farther than the slop is dropped there. An accepted tap then runs a restoring
// divider that produces one quotient bit per cycle for the sidebar row, and the
// block takes no new poll until the tap is done.
// A tap result sits in an output register, so the next poll is accepted while the
// tap waits to be taken; the block stalls only if a second tap finishes first.
module touch_tap_classifier #(
    parameter int X_COORD_BITS = 11,
    parameter int Y_COORD_BITS = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tapc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tapc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // touch_present, touch_x, touch_y
    input  logic [((1+X_COORD_BITS+Y_COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tap_x, tap_y, in_sidebar, sidebar_row
    output logic [tapc_pkg::OUT_W-1:0]       m_tdata
);

    localparam int XW  = X_COORD_BITS;
    localparam int YW  = Y_COORD_BITS;
    localparam int MW0 = (XW > YW) ? XW : YW;
    localparam int MW  = (MW0 > tapc_pkg::SLOP_W) ? MW0 : tapc_pkg::SLOP_W;
    localparam int PW  = 2 * MW;
    localparam int AW  = PW + 1;
    localparam int CW  = $clog2(YW + 1);
    localparam int XCW = (XW > tapc_pkg::WIDTH_W) ? XW : tapc_pkg::WIDTH_W;
    localparam int YCW = (YW > tapc_pkg::MARGIN_W) ? YW : tapc_pkg::MARGIN_W;
    localparam int RW  = tapc_pkg::HEIGHT_W + 1;

    tapc_pkg::tapc_state_t state_reg, state_next;

    logic                          enable_reg;
    logic [tapc_pkg::SLOP_W-1:0]   tap_slop_reg;
    logic [tapc_pkg::WIDTH_W-1:0]  sidebar_width_reg;
    logic [tapc_pkg::MARGIN_W-1:0] sidebar_top_margin_reg;
    logic [tapc_pkg::HEIGHT_W-1:0] sidebar_row_height_reg;

    logic               was_touched_reg, was_touched_next;
    logic [XW-1:0]      last_x_reg, last_x_next;
    logic [YW-1:0]      last_y_reg, last_y_next;
    logic [XW-1:0]      press_x_reg, press_x_next;
    logic [YW-1:0]      press_y_reg, press_y_next;
    logic [AW-1:0]      acc_reg, acc_next;
    logic               side_reg, side_next;
    logic [YW-1:0]      num_reg, num_next;
    logic [RW-1:0]      rem_reg, rem_next;
    logic [YW-1:0]      quo_reg, quo_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [tapc_pkg::OUT_W-1:0] m_tdata_reg, m_tdata_next;

    logic                 touch_present;
    logic [XW-1:0]        touch_x;
    logic [YW-1:0]        touch_y;
    logic                 in_accept;
    logic [XW-1:0]        dx;
    logic [YW-1:0]        dy;
    logic [MW-1:0]        mul_op;
    logic [PW-1:0]        prod;
    logic                 side_now;
    logic                 y_ge_margin;
    logic [YCW-1:0]       y_off;
    logic [tapc_pkg::HEIGHT_W-1:0] row_h;
    logic [RW-1:0]        trial;
    logic                 q_bit;
    logic [tapc_pkg::ROW_W-1:0] row_sat;

    assign touch_present = s_tdata[0];
    assign touch_x       = s_tdata[XW:1];
    assign touch_y       = s_tdata[XW+YW:XW+1];

    assign s_tready  = (state_reg == tapc_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg             <= 1'b1;
            tap_slop_reg           <= tapc_pkg::TAP_SLOP_RESET;
            sidebar_width_reg      <= tapc_pkg::SIDEBAR_WIDTH_RESET;
            sidebar_top_margin_reg <= tapc_pkg::TOP_MARGIN_RESET;
            sidebar_row_height_reg <= tapc_pkg::MIN_ROW_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (tapc_pkg::cfg_idx_t'(cfg_index))
                tapc_pkg::CFG_ENABLE:    enable_reg <= cfg_wdata[0];
                tapc_pkg::CFG_TAP_SLOP:  tap_slop_reg <= cfg_wdata;
                tapc_pkg::CFG_SB_WIDTH:  sidebar_width_reg <= cfg_wdata;
                tapc_pkg::CFG_SB_MARGIN:
                    sidebar_top_margin_reg <= cfg_wdata[tapc_pkg::MARGIN_W-1:0];
                tapc_pkg::CFG_SB_HEIGHT:
                    sidebar_row_height_reg <= cfg_wdata[tapc_pkg::HEIGHT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // shared datapath pieces
    always_comb
    begin
        dx = (last_x_reg >= press_x_reg) ? (last_x_reg - press_x_reg)
                                         : (press_x_reg - last_x_reg);
        dy = (last_y_reg >= press_y_reg) ? (last_y_reg - press_y_reg)
                                         : (press_y_reg - last_y_reg);
        unique case (state_reg)
            tapc_pkg::ST_SQ_Y: mul_op = MW'(dy);
            tapc_pkg::ST_SLOP: mul_op = MW'(tap_slop_reg);
            default:           mul_op = MW'(dx);
        endcase
        prod = PW'(mul_op) * PW'(mul_op);

        side_now    = XCW'(last_x_reg) < XCW'(sidebar_width_reg);
        y_ge_margin = YCW'(last_y_reg) >= YCW'(sidebar_top_margin_reg);
        y_off       = YCW'(last_y_reg) - YCW'(sidebar_top_margin_reg);
        row_h       = (sidebar_row_height_reg < tapc_pkg::MIN_ROW_HEIGHT)
                      ? tapc_pkg::MIN_ROW_HEIGHT : sidebar_row_height_reg;

        trial = {rem_reg[RW-2:0], num_reg[YW-1]};
        q_bit = trial >= RW'(row_h);

        row_sat = (quo_reg > YW'(tapc_pkg::ROW_MAX)) ? tapc_pkg::ROW_MAX
                                                      : quo_reg[tapc_pkg::ROW_W-1:0];
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tapc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath
    always_comb
    begin
        state_next       = state_reg;
        was_touched_next = was_touched_reg;
        last_x_next      = last_x_reg;
        last_y_next      = last_y_reg;
        press_x_next     = press_x_reg;
        press_y_next     = press_y_reg;
        acc_next         = acc_reg;
        side_next        = side_reg;
        num_next         = num_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        cnt_next         = cnt_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;

        unique case (state_reg)
            tapc_pkg::ST_IDLE:
            begin
                if (in_accept && enable_reg)
                begin
                    was_touched_next = touch_present;
                    if (touch_present)
                    begin
                        last_x_next = touch_x;
                        last_y_next = touch_y;
                        if (!was_touched_reg)
                        begin
                            press_x_next = touch_x;
                            press_y_next = touch_y;
                        end
                    end
                    else if (was_touched_reg)
                    begin
                        state_next = tapc_pkg::ST_SQ_X;
                    end
                end
            end
            tapc_pkg::ST_SQ_X:
            begin
                acc_next   = AW'(prod);
                state_next = tapc_pkg::ST_SQ_Y;
            end
            tapc_pkg::ST_SQ_Y:
            begin
                acc_next   = acc_reg + AW'(prod);
                state_next = tapc_pkg::ST_SLOP;
            end
            tapc_pkg::ST_SLOP:
            begin
                state_next = (acc_reg <= AW'(prod)) ? tapc_pkg::ST_PREP
                                                    : tapc_pkg::ST_IDLE;
            end
            tapc_pkg::ST_PREP:
            begin
                side_next  = side_now;
                num_next   = (side_now && y_ge_margin) ? y_off[YW-1:0] : '0;
                rem_next   = '0;
                quo_next   = '0;
                cnt_next   = CW'(YW);
                state_next = tapc_pkg::ST_DIV;
            end
            tapc_pkg::ST_DIV:
            begin
                rem_next = q_bit ? (trial - RW'(row_h)) : trial;
                quo_next = {quo_reg[YW-2:0], q_bit};
                num_next = {num_reg[YW-2:0], 1'b0};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    state_next = tapc_pkg::ST_DONE;
                end
            end
            tapc_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {
                        (tapc_pkg::OUT_W - tapc_pkg::TAP_X_W - tapc_pkg::TAP_Y_W
                         - 1 - tapc_pkg::ROW_W)'(0),
                        row_sat,
                        side_reg,
                        tapc_pkg::TAP_Y_W'(last_y_reg),
                        tapc_pkg::TAP_X_W'(last_x_reg)
                    };
                    state_next    = tapc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tapc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_touched_reg <= 1'b0;
            last_x_reg      <= '0;
            last_y_reg      <= '0;
            press_x_reg     <= '0;
            press_y_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            was_touched_reg <= was_touched_next;
            last_x_reg      <= last_x_next;
            last_y_reg      <= last_y_next;
            press_x_reg     <= press_x_next;
            press_y_reg     <= press_y_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        side_reg    <= side_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// ===== rtl/tapc_checker.sv =====
// port-level checks for the touch tap classifier, bound to the top level
`timescale 1ns / 1ps

module tapc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [tapc_pkg::OUT_W-1:0] m_tdata
);

    localparam int SIDE_BIT = tapc_pkg::TAP_X_W + tapc_pkg::TAP_Y_W;
    localparam int ROW_LO   = SIDE_BIT + 1;
    localparam int ROW_HI   = ROW_LO + tapc_pkg::ROW_W - 1;

    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // content-area taps carry row zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[SIDE_BIT] |-> m_tdata[ROW_HI:ROW_LO] == '0)
        else $error("row set on a content-area tap");

    // a new tap is loaded only by the sequencer, never from the idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("tap appeared without a busy phase");

    // padding bits stay clear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[tapc_pkg::OUT_W-1:ROW_HI+1] == '0)
        else $error("padding bits set in output word");

endmodule

bind touch_tap_classifier tapc_checker u_tapc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
